[rtl/assert_macros.svh]
// assertion macros for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked at every rising edge out of reset
`define ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle implication failed");

// next-cycle implication, checked at every rising edge out of reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle implication failed");

`endif

[rtl/dspg_pkg.sv]
// shared types, constants and codes for the dual-axis step pulse generator
`timescale 1ns / 1ps

package dspg_pkg;

    // velocity word width, sign included
    localparam int SPEED_BITS = 17;
    localparam int VEL_W      = 16;
    localparam int RATE_W     = 20;
    localparam int UDIV_W     = 16;
    localparam int SETUP_W    = 8;
    localparam int SHIFT_W    = 4;
    localparam int PERIOD_W   = 20;
    localparam int MAG_W      = SPEED_BITS - 1;
    localparam int NUM_W      = ((RATE_W > MAG_W) ? RATE_W : MAG_W) + 1;
    localparam int DCNT_W     = $clog2(NUM_W);
    localparam int OUT_W      = ((4 + 2 * SPEED_BITS + 7) / 8) * 8;
    localparam int APB_AW     = 5;

    // largest speed the velocity word can hold
    localparam logic [31:0] SPEED_CAP = (32'd1 << (SPEED_BITS - 1)) - 32'd1;

    typedef logic signed [SPEED_BITS-1:0] speed_t;
    typedef logic signed [SPEED_BITS:0]   diff_t;
    typedef logic signed [SPEED_BITS+1:0] sum_t;
    typedef logic [MAG_W-1:0]             mag_t;
    typedef logic [NUM_W-1:0]             num_t;
    typedef logic [DCNT_W-1:0]            dcnt_t;
    typedef logic [PERIOD_W-1:0]          period_t;
    typedef logic [OUT_W-1:0]             out_t;

    // request kinds carried on tuser
    typedef enum logic [1:0] {
        REQ_TICK = 2'd0,
        REQ_PAN  = 2'd1,
        REQ_TILT = 2'd2,
        REQ_STOP = 2'd3
    } req_t;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_CALC,
        ST_APPLY,
        ST_DIV,
        ST_FIN,
        ST_DONE
    } state_t;

    // register indexes (paddr[4:2])
    localparam logic [2:0] REG_MAX_VELOCITY    = 3'd0;
    localparam logic [2:0] REG_TICK_RATE       = 3'd1;
    localparam logic [2:0] REG_UPDATE_DIVIDER  = 3'd2;
    localparam logic [2:0] REG_DIR_SETUP_TICKS = 3'd3;
    localparam logic [2:0] REG_SMOOTH_SHIFT    = 3'd4;
    localparam logic [2:0] REG_PAN_INVERT      = 3'd5;
    localparam logic [2:0] REG_TILT_INVERT     = 3'd6;

    // register reset values
    localparam logic [VEL_W-1:0]   MAX_VELOCITY_RST    = 16'd20000;
    localparam logic [RATE_W-1:0]  TICK_RATE_RST       = 20'd100000;
    localparam logic [UDIV_W-1:0]  UPDATE_DIVIDER_RST  = 16'd10;
    localparam logic [SETUP_W-1:0] DIR_SETUP_TICKS_RST = 8'd5;
    localparam logic [SHIFT_W-1:0] SMOOTH_SHIFT_RST    = 4'd1;
    localparam logic               PAN_INVERT_RST      = 1'b0;
    localparam logic               TILT_INVERT_RST     = 1'b1;

    // shortest step period
    localparam num_t MIN_PERIOD = num_t'(2);

    // sequencer to datapath controls
    typedef struct packed {
        logic ready;
        logic exec;
        logic calc;
        logic apply;
        logic fin;
        logic load_out;
        logic axis;
    } ctl_t;

    // datapath to sequencer status
    typedef struct packed {
        logic in_valid;
        logic is_tick;
        logic update_due;
        logic no_div;
        logic div_busy;
        logic out_free;
    } stat_t;

endpackage

[rtl/dspg_div.sv]
// shared restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps

module dspg_div (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  dspg_pkg::num_t  numer,
    input  dspg_pkg::mag_t  denom,
    output logic            busy,
    output dspg_pkg::num_t  quot
);

    logic            busy_reg, busy_next;
    dspg_pkg::dcnt_t cnt_reg, cnt_next;
    dspg_pkg::num_t  dq_reg, dq_next;
    dspg_pkg::mag_t  rem_reg, rem_next;
    dspg_pkg::mag_t  den_reg, den_next;

    logic [dspg_pkg::MAG_W:0] shifted;
    logic [dspg_pkg::MAG_W:0] trial;
    logic                     fits;

    // one shift-and-subtract step
    always_comb
    begin
        shifted = {rem_reg, dq_reg[dspg_pkg::NUM_W-1]};
        trial   = shifted - {1'b0, den_reg};
        fits    = shifted >= {1'b0, den_reg};
    end

    // control and datapath next values
    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        dq_next   = dq_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = dspg_pkg::dcnt_t'(dspg_pkg::NUM_W - 1);
            dq_next   = numer;
            rem_next  = '0;
            den_next  = denom;
        end
        else if (busy_reg)
        begin
            dq_next  = {dq_reg[dspg_pkg::NUM_W-2:0], fits};
            rem_next = fits ? trial[dspg_pkg::MAG_W-1:0] : shifted[dspg_pkg::MAG_W-1:0];
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
            end
            else
            begin
                cnt_next = cnt_reg - dspg_pkg::dcnt_t'(1);
            end
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    // operand and result registers
    always_ff @(posedge clk)
    begin
        dq_reg  <= dq_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign busy = busy_reg;
    assign quot = dq_reg;

endmodule

[rtl/dspg_seq.sv]
// sequencer: walks one item through exec, per-axis update and divide
`timescale 1ns / 1ps

module dspg_seq (
    input  logic            clk,
    input  logic            rst_n,
    input  dspg_pkg::stat_t stat,
    output dspg_pkg::ctl_t  ctl
);

    dspg_pkg::state_t state_reg, state_next;
    logic             axis_reg, axis_next;

    // next state
    always_comb
    begin
        state_next = state_reg;
        axis_next  = axis_reg;
        case (state_reg)
            dspg_pkg::ST_IDLE:
            begin
                if (stat.in_valid)
                begin
                    state_next = dspg_pkg::ST_EXEC;
                end
            end
            dspg_pkg::ST_EXEC:
            begin
                if (stat.is_tick && stat.update_due)
                begin
                    state_next = dspg_pkg::ST_CALC;
                    axis_next  = 1'b0;
                end
                else
                begin
                    state_next = dspg_pkg::ST_DONE;
                end
            end
            dspg_pkg::ST_CALC:
            begin
                state_next = dspg_pkg::ST_APPLY;
            end
            dspg_pkg::ST_APPLY:
            begin
                if (!stat.no_div)
                begin
                    state_next = dspg_pkg::ST_DIV;
                end
                else if (axis_reg)
                begin
                    state_next = dspg_pkg::ST_DONE;
                end
                else
                begin
                    state_next = dspg_pkg::ST_CALC;
                    axis_next  = 1'b1;
                end
            end
            dspg_pkg::ST_DIV:
            begin
                if (!stat.div_busy)
                begin
                    state_next = dspg_pkg::ST_FIN;
                end
            end
            dspg_pkg::ST_FIN:
            begin
                if (axis_reg)
                begin
                    state_next = dspg_pkg::ST_DONE;
                end
                else
                begin
                    state_next = dspg_pkg::ST_CALC;
                    axis_next  = 1'b1;
                end
            end
            dspg_pkg::ST_DONE:
            begin
                if (stat.out_free)
                begin
                    state_next = dspg_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = dspg_pkg::ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        ctl          = '0;
        ctl.axis     = axis_reg;
        ctl.ready    = state_reg == dspg_pkg::ST_IDLE;
        ctl.exec     = state_reg == dspg_pkg::ST_EXEC;
        ctl.calc     = state_reg == dspg_pkg::ST_CALC;
        ctl.apply    = state_reg == dspg_pkg::ST_APPLY;
        ctl.fin      = state_reg == dspg_pkg::ST_FIN;
        ctl.load_out = (state_reg == dspg_pkg::ST_DONE) && stat.out_free;
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= dspg_pkg::ST_IDLE;
            axis_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            axis_reg  <= axis_next;
        end
    end

endmodule

[rtl/dual_axis_step_pulse_generator_unit.sv]
// top level: registers, axis state, pulse and smoothing datapath
// from accept to m_tvalid for a tick without update or a non-tick item: the exec state, then
// the done state, which loads the result register once the output is free; a tick that runs the
// velocity update adds, per axis, a smoothing state and an apply state and, where the divider runs,
// its 21 steps, a done check and a period write
// one item at a time, with the single shared divider serving both axes in turn
// reset: rst_n asynchronous, active low; all axis state zero, pins low, registers at defaults
`timescale 1ns / 1ps

module dual_axis_step_pulse_generator_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    // input items
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [15:0]                   s_tdata,   // [15:0] target_velocity
    input  logic [1:0]                    s_tuser,   // [1:0] req_type
    // result items
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [dspg_pkg::OUT_W-1:0]    m_tdata,   // [0] pan_step, [1] pan_dir,
                                                     // [2] tilt_step, [3] tilt_dir,
                                                     // [20:4] pan_speed_now,
                                                     // [37:21] tilt_speed_now
    // configuration
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [dspg_pkg::APB_AW-1:0]   paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);

    // configuration registers
    logic [dspg_pkg::VEL_W-1:0]   max_velocity_reg;
    logic [dspg_pkg::RATE_W-1:0]  tick_rate_reg;
    logic [dspg_pkg::UDIV_W-1:0]  update_divider_reg;
    logic [dspg_pkg::SETUP_W-1:0] dir_setup_ticks_reg;
    logic [dspg_pkg::SHIFT_W-1:0] smooth_shift_reg;
    logic                         pan_invert_reg;
    logic                         tilt_invert_reg;

    // latched item
    dspg_pkg::req_t               req_type_reg;
    logic signed [15:0]           target_velocity_reg;

    // axis state
    dspg_pkg::speed_t             target_reg [2];
    dspg_pkg::speed_t             target_next [2];
    dspg_pkg::speed_t             speed_reg [2];
    dspg_pkg::speed_t             speed_next [2];
    dspg_pkg::period_t            period_reg [2];
    dspg_pkg::period_t            period_next [2];
    dspg_pkg::period_t            count_reg [2];
    dspg_pkg::period_t            count_next [2];
    logic [dspg_pkg::SETUP_W-1:0] hold_reg [2];
    logic [dspg_pkg::SETUP_W-1:0] hold_next [2];
    logic                         heading_reg [2];
    logic                         heading_next [2];
    logic                         step_reg [2];
    logic                         step_next [2];
    logic [dspg_pkg::UDIV_W-1:0]  update_count_reg, update_count_next;
    dspg_pkg::speed_t             new_speed_reg, new_speed_next;

    // output register
    logic                         m_tvalid_reg, m_tvalid_next;
    dspg_pkg::out_t               m_tdata_reg, m_tdata_next;

    // control
    dspg_pkg::ctl_t               ctl;
    dspg_pkg::stat_t              stat;

    // datapath wires
    logic [31:0]                  lim_wide;
    dspg_pkg::sum_t               lim_s;
    dspg_pkg::sum_t               tv_s;
    dspg_pkg::speed_t             tv_clamped;
    logic [dspg_pkg::UDIV_W:0]    uc_inc;
    logic                         update_due;
    dspg_pkg::diff_t              diff;
    dspg_pkg::diff_t              delta;
    dspg_pkg::sum_t               sum;
    dspg_pkg::speed_t             cur_speed;
    logic                         speed_changed;
    logic                         speed_zero;
    logic                         dir_new;
    logic                         invert_sel;
    dspg_pkg::speed_t             neg_speed;
    dspg_pkg::mag_t               mag;
    dspg_pkg::num_t               numer;
    dspg_pkg::num_t               quot;
    dspg_pkg::num_t               period_q;
    logic                         div_busy;
    logic                         cfg_wr;
    logic                         in_accept;

    // handshake
    assign in_accept = s_tvalid && ctl.ready;
    assign s_tready  = ctl.ready;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;
    assign pready    = 1'b1;
    assign cfg_wr    = psel && penable && pwrite && pready;

    // effective speed limit
    always_comb
    begin
        lim_wide = {16'd0, max_velocity_reg};
        if (lim_wide > dspg_pkg::SPEED_CAP)
        begin
            lim_wide = dspg_pkg::SPEED_CAP;
        end
        lim_s = dspg_pkg::sum_t'(lim_wide);
    end

    // target saturation
    always_comb
    begin
        tv_s = dspg_pkg::sum_t'(target_velocity_reg);
        if (tv_s > lim_s)
        begin
            tv_clamped = dspg_pkg::speed_t'(lim_s);
        end
        else if (tv_s < -lim_s)
        begin
            tv_clamped = dspg_pkg::speed_t'(-lim_s);
        end
        else
        begin
            tv_clamped = dspg_pkg::speed_t'(tv_s);
        end
    end

    // smoothing update divider
    always_comb
    begin
        uc_inc     = {1'b0, update_count_reg} + 17'd1;
        update_due = uc_inc >= {1'b0, update_divider_reg};
    end

    // smoothing step for the selected axis
    always_comb
    begin
        cur_speed = speed_reg[ctl.axis];
        diff      = dspg_pkg::diff_t'(target_reg[ctl.axis]) - dspg_pkg::diff_t'(cur_speed);
        delta     = diff >>> smooth_shift_reg;
        sum       = dspg_pkg::sum_t'(cur_speed) + dspg_pkg::sum_t'(delta);
        if (sum > lim_s)
        begin
            new_speed_next = dspg_pkg::speed_t'(lim_s);
        end
        else if (sum < -lim_s)
        begin
            new_speed_next = dspg_pkg::speed_t'(-lim_s);
        end
        else
        begin
            new_speed_next = dspg_pkg::speed_t'(sum);
        end
    end

    // direction, magnitude and divider operand for the new speed
    always_comb
    begin
        speed_changed = new_speed_reg != speed_reg[ctl.axis];
        speed_zero    = new_speed_reg == '0;
        invert_sel    = ctl.axis ? tilt_invert_reg : pan_invert_reg;
        dir_new       = (!new_speed_reg[dspg_pkg::SPEED_BITS-1]) ^ invert_sel;
        neg_speed     = -new_speed_reg;
        mag           = new_speed_reg[dspg_pkg::SPEED_BITS-1] ?
                        dspg_pkg::mag_t'(neg_speed) : dspg_pkg::mag_t'(new_speed_reg);
        numer         = dspg_pkg::num_t'(tick_rate_reg) + dspg_pkg::num_t'(mag >> 1);
        period_q      = (quot < dspg_pkg::MIN_PERIOD) ? dspg_pkg::MIN_PERIOD : quot;
    end

    // status to the sequencer
    always_comb
    begin
        stat            = '0;
        stat.in_valid   = s_tvalid;
        stat.is_tick    = req_type_reg == dspg_pkg::REQ_TICK;
        stat.update_due = update_due;
        stat.no_div     = (!speed_changed) || speed_zero;
        stat.div_busy   = div_busy;
        stat.out_free   = (!m_tvalid_reg) || m_tready;
    end

    // axis state next values
    always_comb
    begin
        logic [dspg_pkg::PERIOD_W:0] cnt_inc;
        cnt_inc = '0;
        for (int a = 0; a < 2; a++)
        begin
            target_next[a]  = target_reg[a];
            speed_next[a]   = speed_reg[a];
            period_next[a]  = period_reg[a];
            count_next[a]   = count_reg[a];
            hold_next[a]    = hold_reg[a];
            heading_next[a] = heading_reg[a];
            step_next[a]    = step_reg[a];
        end
        update_count_next = update_count_reg;

        // item execution
        if (ctl.exec)
        begin
            case (req_type_reg)
                dspg_pkg::REQ_TICK:
                begin
                    for (int a = 0; a < 2; a++)
                    begin
                        if (hold_reg[a] != '0)
                        begin
                            hold_next[a] = hold_reg[a] - 8'd1;
                            step_next[a] = 1'b0;
                        end
                        else if (period_reg[a] != '0)
                        begin
                            if (count_reg[a] == '0)
                            begin
                                step_next[a] = 1'b1;
                            end
                            else if (count_reg[a] == dspg_pkg::period_t'(1))
                            begin
                                step_next[a] = 1'b0;
                            end
                            cnt_inc = {1'b0, count_reg[a]} + 21'd1;
                            if (cnt_inc >= {1'b0, period_reg[a]})
                            begin
                                count_next[a] = '0;
                            end
                            else
                            begin
                                count_next[a] = cnt_inc[dspg_pkg::PERIOD_W-1:0];
                            end
                        end
                    end
                    update_count_next = update_due ? '0 : uc_inc[dspg_pkg::UDIV_W-1:0];
                end
                dspg_pkg::REQ_PAN:
                begin
                    target_next[0] = tv_clamped;
                end
                dspg_pkg::REQ_TILT:
                begin
                    target_next[1] = tv_clamped;
                end
                dspg_pkg::REQ_STOP:
                begin
                    for (int a = 0; a < 2; a++)
                    begin
                        target_next[a] = '0;
                        speed_next[a]  = '0;
                        period_next[a] = '0;
                        step_next[a]   = 1'b0;
                    end
                end
                default:
                begin
                end
            endcase
        end

        // new speed takes effect
        if (ctl.apply && speed_changed)
        begin
            speed_next[ctl.axis] = new_speed_reg;
            if (speed_zero)
            begin
                period_next[ctl.axis] = '0;
                count_next[ctl.axis]  = '0;
                step_next[ctl.axis]   = 1'b0;
            end
            else if (dir_new != heading_reg[ctl.axis])
            begin
                heading_next[ctl.axis] = dir_new;
                step_next[ctl.axis]    = 1'b0;
                count_next[ctl.axis]   = '0;
                hold_next[ctl.axis]    = dir_setup_ticks_reg;
            end
        end

        // period from the divider
        if (ctl.fin)
        begin
            period_next[ctl.axis] = dspg_pkg::period_t'(period_q);
            if (count_reg[ctl.axis] >= dspg_pkg::period_t'(period_q))
            begin
                count_next[ctl.axis] = '0;
            end
        end
    end

    // axis state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int a = 0; a < 2; a++)
            begin
                target_reg[a]  <= '0;
                speed_reg[a]   <= '0;
                period_reg[a]  <= '0;
                count_reg[a]   <= '0;
                hold_reg[a]    <= '0;
                heading_reg[a] <= 1'b0;
                step_reg[a]    <= 1'b0;
            end
            update_count_reg <= '0;
        end
        else
        begin
            for (int a = 0; a < 2; a++)
            begin
                target_reg[a]  <= target_next[a];
                speed_reg[a]   <= speed_next[a];
                period_reg[a]  <= period_next[a];
                count_reg[a]   <= count_next[a];
                hold_reg[a]    <= hold_next[a];
                heading_reg[a] <= heading_next[a];
                step_reg[a]    <= step_next[a];
            end
            update_count_reg <= update_count_next;
        end
    end

    // item and smoothing payload
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            req_type_reg        <= dspg_pkg::req_t'(s_tuser);
            target_velocity_reg <= s_tdata;
        end
        if (ctl.calc)
        begin
            new_speed_reg <= new_speed_next;
        end
    end

    // result register
    always_comb
    begin
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        if (ctl.load_out)
        begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = dspg_pkg::out_t'({speed_reg[1], speed_reg[0], heading_reg[1],
                                              step_reg[1], heading_reg[0], step_reg[0]});
        end
        else if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        m_tdata_reg <= m_tdata_next;
    end

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_velocity_reg    <= dspg_pkg::MAX_VELOCITY_RST;
            tick_rate_reg       <= dspg_pkg::TICK_RATE_RST;
            update_divider_reg  <= dspg_pkg::UPDATE_DIVIDER_RST;
            dir_setup_ticks_reg <= dspg_pkg::DIR_SETUP_TICKS_RST;
            smooth_shift_reg    <= dspg_pkg::SMOOTH_SHIFT_RST;
            pan_invert_reg      <= dspg_pkg::PAN_INVERT_RST;
            tilt_invert_reg     <= dspg_pkg::TILT_INVERT_RST;
        end
        else if (cfg_wr)
        begin
            case (paddr[4:2])
                dspg_pkg::REG_MAX_VELOCITY:    max_velocity_reg    <= pwdata[15:0];
                dspg_pkg::REG_TICK_RATE:       tick_rate_reg       <= pwdata[19:0];
                dspg_pkg::REG_UPDATE_DIVIDER:  update_divider_reg  <= pwdata[15:0];
                dspg_pkg::REG_DIR_SETUP_TICKS: dir_setup_ticks_reg <= pwdata[7:0];
                dspg_pkg::REG_SMOOTH_SHIFT:    smooth_shift_reg    <= pwdata[3:0];
                dspg_pkg::REG_PAN_INVERT:      pan_invert_reg      <= pwdata[0];
                dspg_pkg::REG_TILT_INVERT:     tilt_invert_reg     <= pwdata[0];
                default:
                begin
                end
            endcase
        end
    end

    // configuration reads
    always_comb
    begin
        case (paddr[4:2])
            dspg_pkg::REG_MAX_VELOCITY:    prdata = {16'd0, max_velocity_reg};
            dspg_pkg::REG_TICK_RATE:       prdata = {12'd0, tick_rate_reg};
            dspg_pkg::REG_UPDATE_DIVIDER:  prdata = {16'd0, update_divider_reg};
            dspg_pkg::REG_DIR_SETUP_TICKS: prdata = {24'd0, dir_setup_ticks_reg};
            dspg_pkg::REG_SMOOTH_SHIFT:    prdata = {28'd0, smooth_shift_reg};
            dspg_pkg::REG_PAN_INVERT:      prdata = {31'd0, pan_invert_reg};
            dspg_pkg::REG_TILT_INVERT:     prdata = {31'd0, tilt_invert_reg};
            default:                       prdata = '0;
        endcase
    end

    // sequencer
    dspg_seq u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .stat  (stat),
        .ctl   (ctl)
    );

    // shared period divider
    dspg_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (ctl.apply && !stat.no_div),
        .numer (numer),
        .denom (mag),
        .busy  (div_busy),
        .quot  (quot)
    );

endmodule

[rtl/dspg_checker.sv]
// port-level checker for the step pulse generator, bound to the top level
`timescale 1ns / 1ps
`include "assert_macros.svh"

module dspg_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       s_tvalid,
    input logic                       s_tready,
    input logic                       m_tvalid,
    input logic                       m_tready,
    input logic [dspg_pkg::OUT_W-1:0] m_tdata
);

    // stalled result holds
    `ASSERT_NEXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

    // one item at a time: busy right after an accept
    `ASSERT_NEXT(a_busy_after_accept, clk, rst_n, s_tvalid && s_tready, !s_tready)

    // a high step pin only on a moving axis
    `ASSERT_IMP(a_pan_step_moving, clk, rst_n, m_tvalid && m_tdata[0], m_tdata[20:4] != '0)
    `ASSERT_IMP(a_tilt_step_moving, clk, rst_n, m_tvalid && m_tdata[2], m_tdata[37:21] != '0)

endmodule

bind dual_axis_step_pulse_generator_unit dspg_checker u_dspg_checker (.*);

[bench/dspg_result_check.sv]
// result checker for the dual-axis step pulse generator: pin and speed prediction per item
`timescale 1ns / 1ps

module dspg_result_check (
    input  logic                           clk,
    input  logic                           rst_n,
    // input channel, observed
    input  logic                           s_tvalid,
    input  logic                           s_tready,
    input  logic [15:0]                    s_tdata,   // [15:0] target_velocity
    input  logic [1:0]                     s_tuser,   // [1:0] req_type
    // result channel, observed
    input  logic                           m_tvalid,
    input  logic                           m_tready,
    input  logic [dspg_pkg::OUT_W-1:0]     m_tdata,   // [0] pan_step, [1] pan_dir,
                                                      // [2] tilt_step, [3] tilt_dir,
                                                      // [20:4] pan_speed_now,
                                                      // [37:21] tilt_speed_now
    // configuration port, observed
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [dspg_pkg::APB_AW-1:0]    paddr,
    input  logic [31:0]                    pwdata,
    input  logic                           pready,
    // status for the bench top
    output int                             mismatches,
    output int                             outstanding
);

    // pin levels and speeds expected after one item
    typedef struct packed {
        logic             pan_step;
        logic             pan_dir;
        logic             tilt_step;
        logic             tilt_dir;
        dspg_pkg::speed_t pan_speed;
        dspg_pkg::speed_t tilt_speed;
    } pin_state_t;

    pin_state_t pin_forecast_q[$];

    // register copies
    logic [15:0] vel_cap_reg;
    logic [19:0] rate_reg;
    logic [15:0] divider_reg;
    logic [7:0]  setup_reg;
    logic [3:0]  shift_reg;
    logic        pan_inv_reg;
    logic        tilt_inv_reg;

    // axis state, index 0 pan, 1 tilt
    dspg_pkg::speed_t  target_v [2];
    dspg_pkg::speed_t  speed_v  [2];
    dspg_pkg::period_t period_v [2];
    dspg_pkg::period_t count_v  [2];
    logic [7:0]        hold_v   [2];
    logic              heading_v[2];
    logic              step_lvl [2];
    logic [15:0]       smooth_count;

    task automatic reset_model();
        int a;
        vel_cap_reg  = dspg_pkg::MAX_VELOCITY_RST;
        rate_reg     = dspg_pkg::TICK_RATE_RST;
        divider_reg  = dspg_pkg::UPDATE_DIVIDER_RST;
        setup_reg    = dspg_pkg::DIR_SETUP_TICKS_RST;
        shift_reg    = dspg_pkg::SMOOTH_SHIFT_RST;
        pan_inv_reg  = dspg_pkg::PAN_INVERT_RST;
        tilt_inv_reg = dspg_pkg::TILT_INVERT_RST;
        for (a = 0; a < 2; a++)
        begin
            target_v[a]  = '0;
            speed_v[a]   = '0;
            period_v[a]  = '0;
            count_v[a]   = '0;
            hold_v[a]    = '0;
            heading_v[a] = 1'b0;
            step_lvl[a]  = 1'b0;
        end
        smooth_count = '0;
        pin_forecast_q.delete();
        outstanding = 0;
    endtask

    task automatic set_register(input logic [2:0] idx, input logic [31:0] val);
        case (idx)
            dspg_pkg::REG_MAX_VELOCITY:    vel_cap_reg  = val[15:0];
            dspg_pkg::REG_TICK_RATE:       rate_reg     = val[19:0];
            dspg_pkg::REG_UPDATE_DIVIDER:  divider_reg  = val[15:0];
            dspg_pkg::REG_DIR_SETUP_TICKS: setup_reg    = val[7:0];
            dspg_pkg::REG_SMOOTH_SHIFT:    shift_reg    = val[3:0];
            dspg_pkg::REG_PAN_INVERT:      pan_inv_reg  = val[0];
            dspg_pkg::REG_TILT_INVERT:     tilt_inv_reg = val[0];
            default: ;
        endcase
    endtask

    // limit is the smaller of the register and what the speed word holds
    function automatic longint clamp_to_limit(input longint v);
        longint lim;
        lim = (longint'(vel_cap_reg) < longint'(dspg_pkg::SPEED_CAP)) ?
              longint'(vel_cap_reg) : longint'(dspg_pkg::SPEED_CAP);
        if (v > lim)
            return lim;
        if (v < -lim)
            return -lim;
        return v;
    endfunction

    // one tick of the step counter, or of the reversal hold
    task automatic advance_pulse(input int a);
        int nxt;
        if (hold_v[a] != 8'd0)
        begin
            hold_v[a]   = hold_v[a] - 8'd1;
            step_lvl[a] = 1'b0;
        end
        else if (period_v[a] != '0)
        begin
            if (count_v[a] == 20'd0)
                step_lvl[a] = 1'b1;
            else if (count_v[a] == 20'd1)
                step_lvl[a] = 1'b0;
            nxt = int'(count_v[a]) + 1;
            if (nxt >= int'(period_v[a]))
                nxt = 0;
            count_v[a] = dspg_pkg::period_t'(nxt);
        end
    endtask

    // move speed toward target, then redo direction and period on a change
    task automatic retime_axis(input int a, input logic inv);
        longint cur;
        longint diff;
        longint nxt;
        longint mag;
        longint per;
        logic   dir;
        cur  = longint'(speed_v[a]);
        diff = longint'(target_v[a]) - cur;
        nxt  = clamp_to_limit(cur + (diff >>> shift_reg));
        if (nxt != cur)
        begin
            speed_v[a] = dspg_pkg::speed_t'(nxt);
            if (nxt == 0)
            begin
                period_v[a] = '0;
                count_v[a]  = '0;
                step_lvl[a] = 1'b0;
            end
            else
            begin
                dir = (nxt > 0) ^ inv;
                // reversal: pin low, count restarts, setup hold reloaded
                if (dir != heading_v[a])
                begin
                    heading_v[a] = dir;
                    step_lvl[a]  = 1'b0;
                    count_v[a]   = '0;
                    hold_v[a]    = setup_reg;
                end
                mag = (nxt > 0) ? nxt : -nxt;
                per = (longint'(rate_reg) + mag / 2) / mag;
                if (per < 2)
                    per = 2;
                period_v[a] = dspg_pkg::period_t'(per);
                if (count_v[a] >= period_v[a])
                    count_v[a] = '0;
            end
        end
    endtask

    // apply one accepted item and queue the pins it should leave
    task automatic apply_request(input dspg_pkg::req_t kind, input logic [15:0] raw);
        int         a;
        int         uc;
        pin_state_t fc;
        case (kind)
            dspg_pkg::REQ_TICK:
            begin
                advance_pulse(0);
                advance_pulse(1);
                uc = int'(smooth_count) + 1;
                if (uc >= int'(divider_reg))
                begin
                    uc = 0;
                    retime_axis(0, pan_inv_reg);
                    retime_axis(1, tilt_inv_reg);
                end
                smooth_count = uc[15:0];
            end
            dspg_pkg::REQ_PAN:
                target_v[0] = dspg_pkg::speed_t'(clamp_to_limit(longint'($signed(raw))));
            dspg_pkg::REQ_TILT:
                target_v[1] = dspg_pkg::speed_t'(clamp_to_limit(longint'($signed(raw))));
            default:
            begin
                // stop keeps counts, holds and headings
                for (a = 0; a < 2; a++)
                begin
                    target_v[a] = '0;
                    speed_v[a]  = '0;
                    period_v[a] = '0;
                    step_lvl[a] = 1'b0;
                end
            end
        endcase
        fc.pan_step   = step_lvl[0];
        fc.pan_dir    = heading_v[0];
        fc.tilt_step  = step_lvl[1];
        fc.tilt_dir   = heading_v[1];
        fc.pan_speed  = speed_v[0];
        fc.tilt_speed = speed_v[1];
        pin_forecast_q.push_back(fc);
        outstanding = outstanding + 1;
    endtask

    task automatic report_mismatch(input string what, input longint got, input longint want);
        mismatches = mismatches + 1;
        $display("[%0t] %s: got %0d, expected %0d", $time, what, got, want);
    endtask

    task automatic check_result(input logic [dspg_pkg::OUT_W-1:0] d);
        pin_state_t want;
        if (pin_forecast_q.size() == 0)
        begin
            report_mismatch("result item with nothing pending", longint'(d[37:0]), 0);
        end
        else
        begin
            want = pin_forecast_q.pop_front();
            outstanding = outstanding - 1;
            if (d[0] !== want.pan_step)
                report_mismatch("pan_step", longint'(d[0]), longint'(want.pan_step));
            if (d[1] !== want.pan_dir)
                report_mismatch("pan_dir", longint'(d[1]), longint'(want.pan_dir));
            if (d[2] !== want.tilt_step)
                report_mismatch("tilt_step", longint'(d[2]), longint'(want.tilt_step));
            if (d[3] !== want.tilt_dir)
                report_mismatch("tilt_dir", longint'(d[3]), longint'(want.tilt_dir));
            if (d[20:4] !== want.pan_speed)
                report_mismatch("pan_speed_now", longint'($signed(d[20:4])),
                                longint'(want.pan_speed));
            if (d[37:21] !== want.tilt_speed)
                report_mismatch("tilt_speed_now", longint'($signed(d[37:21])),
                                longint'(want.tilt_speed));
        end
    endtask

    // results are checked before the same edge's input is applied
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reset_model();
        end
        else
        begin
            if (psel && penable && pwrite && pready)
                set_register(paddr[4:2], pwdata);
            if (m_tvalid && m_tready)
                check_result(m_tdata);
            if (s_tvalid && s_tready)
                apply_request(dspg_pkg::req_t'(s_tuser), s_tdata);
        end
    end

endmodule

[bench/tb_dual_axis_step_pulse_generator_unit.sv]
// bench top for the dual-axis step pulse generator: clock, reset, stimulus and verdict
`timescale 1ns / 1ps

module tb_dual_axis_step_pulse_generator_unit;

    localparam int IDLE_LIMIT   = 5000;
    localparam int DRAIN_CYCLES = 60;
    localparam int BACKLOG_HOLD = 300;

    logic                          clk;
    logic                          rst_n;
    logic                          s_tvalid;
    logic                          s_tready;
    logic [15:0]                   s_tdata;
    logic [1:0]                    s_tuser;
    logic                          m_tvalid;
    logic                          m_tready;
    logic [dspg_pkg::OUT_W-1:0]    m_tdata;
    logic                          psel;
    logic                          penable;
    logic                          pwrite;
    logic [dspg_pkg::APB_AW-1:0]   paddr;
    logic [31:0]                   pwdata;
    logic [31:0]                   prdata;
    logic                          pready;

    int mismatches;
    int outstanding;
    int quiet_cycles = 0;
    int rx_hold_len  = 0;
    bit tx_steady    = 1'b0;
    bit rx_steady    = 1'b0;

    dual_axis_step_pulse_generator_unit uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    dspg_result_check result_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .pready      (pready),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    // 100 MHz clock
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // cycles since the last item moved on either side
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        wait (quiet_cycles >= IDLE_LIMIT);
        $display("dual_axis_step_pulse_generator_unit verification failed");
        $finish;
    end

    // result side: random stall per item, plus one long hold-off on request
    initial
    begin
        int gap;
        m_tready = 1'b0;
        @(negedge clk);
        forever
        begin
            gap = rx_steady ? 0 : $urandom_range(0, 6);
            if (rx_hold_len > 0)
            begin
                gap = rx_hold_len;
                rx_hold_len = 0;
            end
            if (gap > 0)
            begin
                m_tready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            m_tready <= 1'b1;
            do
                @(posedge clk);
            while (!(m_tvalid && m_tready));
            @(negedge clk);
        end
    end

    // one item on the input side, entered and left at a falling edge
    task automatic send(input dspg_pkg::req_t kind, input logic [15:0] vel);
        int gap;
        gap = tx_steady ? 0 : $urandom_range(0, 6);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= vel;
        do
            @(posedge clk);
        while (!(s_tvalid && s_tready));
        @(negedge clk);
    endtask

    task automatic pause_until_drained();
        s_tvalid <= 1'b0;
        while (outstanding != 0)
            @(negedge clk);
    endtask

    // block idle and past its longest update before touching registers
    task automatic settle();
        pause_until_drained();
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge clk);
    endtask

    task automatic configure(input logic [15:0] max_vel, input logic [19:0] rate,
                             input logic [15:0] divider, input logic [7:0] setup,
                             input logic [3:0] shift, input logic pan_inv,
                             input logic tilt_inv);
        settle();
        write_reg(dspg_pkg::REG_MAX_VELOCITY, 32'(max_vel));
        write_reg(dspg_pkg::REG_TICK_RATE, 32'(rate));
        write_reg(dspg_pkg::REG_UPDATE_DIVIDER, 32'(divider));
        write_reg(dspg_pkg::REG_DIR_SETUP_TICKS, 32'(setup));
        write_reg(dspg_pkg::REG_SMOOTH_SHIFT, 32'(shift));
        write_reg(dspg_pkg::REG_PAN_INVERT, 32'(pan_inv));
        write_reg(dspg_pkg::REG_TILT_INVERT, 32'(tilt_inv));
    endtask

    // mix of full-range, moderate and extreme target velocities
    function automatic logic [15:0] pick_velocity();
        int          sel;
        logic [15:0] mag;
        sel = $urandom_range(0, 9);
        mag = 16'($urandom_range(1, 2000));
        if (sel < 4)
            return 16'($urandom);
        if (sel < 6)
            return mag;
        if (sel < 8)
            return -mag;
        case ($urandom_range(0, 4))
            0:       return 16'h7FFF;
            1:       return 16'h8000;
            2:       return 16'h0000;
            3:       return 16'hFFFF;
            default: return 16'h0001;
        endcase
    endfunction

    // mostly ticks with occasional retargets and rare stops
    task automatic random_phase(input int n_items);
        int i;
        int r;
        for (i = 0; i < n_items; i++)
        begin
            if (i == n_items / 2)
                pause_until_drained();
            r = $urandom_range(0, 99);
            if (r < 74)
                send(dspg_pkg::REQ_TICK, 16'($urandom));
            else if (r < 86)
                send(dspg_pkg::REQ_PAN, pick_velocity());
            else if (r < 98)
                send(dspg_pkg::REQ_TILT, pick_velocity());
            else
                send(dspg_pkg::REQ_STOP, 16'($urandom));
        end
    endtask

    initial
    begin
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = '0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset defaults: saturating targets, first smoothing update
        send(dspg_pkg::REQ_STOP, 16'hFFFF);
        send(dspg_pkg::REQ_PAN, 16'h7FFF);
        send(dspg_pkg::REQ_TILT, 16'h8000);
        repeat (11) send(dspg_pkg::REQ_TICK, 16'h0000);
        send(dspg_pkg::REQ_PAN, 16'h8001);

        // divider of zero, no setup hold, unshifted smoothing, pan pin flipped
        settle();
        write_reg(dspg_pkg::REG_UPDATE_DIVIDER, 32'd0);
        write_reg(dspg_pkg::REG_DIR_SETUP_TICKS, 32'd0);
        write_reg(dspg_pkg::REG_SMOOTH_SHIFT, 32'd0);
        write_reg(dspg_pkg::REG_PAN_INVERT, 32'd1);
        repeat (3) send(dspg_pkg::REQ_TICK, 16'hFFFF);
        send(dspg_pkg::REQ_STOP, 16'h0000);

        // zero limit clamps everything
        settle();
        write_reg(dspg_pkg::REG_MAX_VELOCITY, 32'd0);
        send(dspg_pkg::REQ_TILT, 16'h7FFF);
        send(dspg_pkg::REQ_TICK, 16'h0000);

        // divider lowered below the running count
        settle();
        write_reg(dspg_pkg::REG_MAX_VELOCITY, 32'd20000);
        write_reg(dspg_pkg::REG_UPDATE_DIVIDER, 32'd5);
        send(dspg_pkg::REQ_PAN, 16'h0100);
        repeat (3) send(dspg_pkg::REQ_TICK, 16'h5A5A);
        settle();
        write_reg(dspg_pkg::REG_UPDATE_DIVIDER, 32'd2);
        send(dspg_pkg::REQ_TICK, 16'h0000);

        // random phases over a spread of settings
        configure(16'd20000, 20'd100000, 16'd1, 8'd3, 4'd1, 1'b0, 1'b1);
        random_phase(220);

        // backlog: receiver holds off while the sender streams
        configure(16'd65535, 20'd1048575, 16'd2, 8'd255, 4'd0, 1'b1, 1'b0);
        tx_steady   = 1'b1;
        rx_hold_len = BACKLOG_HOLD;
        random_phase(220);
        tx_steady = 1'b0;

        configure(16'd1, 20'd1, 16'd3, 8'd0, 4'd15, 1'b0, 1'b0);
        random_phase(200);

        configure(16'd40000, 20'd200000, 16'd65535, 8'd2, 4'd2, 1'b1, 1'b1);
        random_phase(60);

        // no idling on either side
        configure(16'd5000, 20'd50000, 16'd0, 8'd10, 4'd2, 1'b1, 1'b1);
        tx_steady = 1'b1;
        rx_steady = 1'b1;
        random_phase(220);
        tx_steady = 1'b0;
        rx_steady = 1'b0;

        configure(16'd300, 20'd1000, 16'd4, 8'd1, 4'd3, 1'b0, 1'b1);
        random_phase(220);

        configure(16'd65535, 20'd65535, 16'd1, 8'd7, 4'd4, 1'b1, 1'b0);
        random_phase(220);

        // drain and let any late item show up
        pause_until_drained();
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (mismatches == 0)
            $display("dual_axis_step_pulse_generator_unit verification clean");
        else
            $display("dual_axis_step_pulse_generator_unit verification failed");
        $finish;
    end

endmodule
